@@ src/srsc_pkg.sv @@
// shared types, constants and clamp helper for the scissor stack clipper
`default_nettype none
package srsc_pkg;

	localparam int StackDepthDef = 16;
	localparam int ScreenW = 14;
	localparam int RectW = 15;
	localparam int InW = 16;
	localparam int CoordW = 20;
	localparam logic [ScreenW-1:0] ScreenWidthRst = ScreenW'(1920);
	localparam logic [ScreenW-1:0] ScreenHeightRst = ScreenW'(1080);

	// configuration register indexes
	localparam logic CfgScreenWidth = 1'b0;
	localparam logic CfgScreenHeight = 1'b1;

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_TEST  = 3'd2,
		OP_CLIP  = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		logic [RectW-1:0] x;
		logic [RectW-1:0] y;
		logic [RectW-1:0] w;
		logic [RectW-1:0] h;
	} rect_t;

	typedef struct packed {
		coord_t pos;
		coord_t len;
	} span_t;

	typedef struct packed {
		logic  push;
		logic  pop;
		logic  clear;
		rect_t entry;
	} stack_cmd_t;

	typedef struct packed {
		rect_t r;
		logic  hit;
		logic  ignored;
	} result_t;

	// cut one axis of a span to a bounding span
	function automatic span_t clamp_span(span_t a, span_t b);
		coord_t p;
		coord_t l;
		span_t  o;
		p = a.pos;
		l = a.len;
		if (p < b.pos) begin
			l = l - (b.pos - p);
			p = b.pos;
		end
		if (p + l > b.pos + b.len) begin
			l = b.pos + b.len - p;
		end
		o.pos = p;
		o.len = l;
		return o;
	endfunction

	// widen a stored coordinate
	function automatic coord_t from_rect(logic [RectW-1:0] v);
		return coord_t'({1'b0, v});
	endfunction

endpackage
`default_nettype wire

@@ src/scissor_rect_stack_clipper.sv @@
// scissor stack clipper: input register, stack, operation logic, result register
// flow: an accepted word is held in the input register, then its result word in the result register
// throughput: one word per cycle while out_stall is low; the stack is updated in the execute step
// input stall follows the output stall in the same cycle while both stages hold words
// reset: stack depth zero, screen size 1920 x 1080, both pipeline stages empty
`default_nettype none
module scissor_rect_stack_clipper #(
	parameter int STACK_DEPTH = srsc_pkg::StackDepthDef,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [srsc_pkg::ScreenW-1:0]    cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [2:0]                      op,
	input  wire logic signed [srsc_pkg::InW-1:0] rect_x,
	input  wire logic signed [srsc_pkg::InW-1:0] rect_y,
	input  wire logic signed [srsc_pkg::InW-1:0] rect_w,
	input  wire logic signed [srsc_pkg::InW-1:0] rect_h,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [srsc_pkg::RectW-1:0]           out_x,
	output logic [srsc_pkg::RectW-1:0]           out_y,
	output logic [srsc_pkg::RectW-1:0]           out_w,
	output logic [srsc_pkg::RectW-1:0]           out_h,
	output logic                                 hit,
	output logic [CW-1:0]                        stack_depth,
	output logic                                 ignored
);

	logic [srsc_pkg::ScreenW-1:0]    scr_width_q;
	logic [srsc_pkg::ScreenW-1:0]    scr_height_q;
	logic                            valid_s1;
	logic [2:0]                      op_s1;
	logic signed [srsc_pkg::InW-1:0] x_s1, y_s1, w_s1, h_s1;
	logic                            out_valid_q;
	srsc_pkg::result_t               res_q;
	logic [CW-1:0]                   depth_q;
	logic                            advance;
	logic                            fire;
	srsc_pkg::rect_t                 top;
	srsc_pkg::rect_t                 below;
	logic [CW-1:0]                   count;
	srsc_pkg::result_t               res;
	srsc_pkg::stack_cmd_t            cmd;
	logic [CW-1:0]                   next_count;

	// handshake control
	assign advance = !out_valid_q || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// screen size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_width_q <= srsc_pkg::ScreenWidthRst;
			scr_height_q <= srsc_pkg::ScreenHeightRst;
		end else if (cfg_we) begin
			if (cfg_index == srsc_pkg::CfgScreenWidth) begin
				scr_width_q <= cfg_data;
			end else begin
				scr_height_q <= cfg_data;
			end
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1 <= op;
			x_s1 <= rect_x;
			y_s1 <= rect_y;
			w_s1 <= rect_w;
			h_s1 <= rect_h;
		end
	end

	srsc_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.apply (fire),
		.cmd   (cmd),
		.top   (top),
		.below (below),
		.count (count)
	);

	srsc_alu #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_alu (
		.op           (op_s1),
		.rect_x       (x_s1),
		.rect_y       (y_s1),
		.rect_w       (w_s1),
		.rect_h       (h_s1),
		.screen_width (scr_width_q),
		.screen_height(scr_height_q),
		.top          (top),
		.below        (below),
		.count        (count),
		.res          (res),
		.cmd          (cmd),
		.next_count   (next_count)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
			depth_q <= next_count;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = res_q.r.x;
	assign out_y = res_q.r.y;
	assign out_w = res_q.r.w;
	assign out_h = res_q.r.h;
	assign hit = res_q.hit;
	assign ignored = res_q.ignored;
	assign stack_depth = depth_q;

endmodule
`default_nettype wire

@@ src/srsc_stack.sv @@
// clip rectangle stack: entry array, registered top and under-top entries, depth counter
`default_nettype none
module srsc_stack #(
	parameter int STACK_DEPTH = srsc_pkg::StackDepthDef,
	localparam int CW = $clog2(STACK_DEPTH + 1),
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               apply,
	input  wire srsc_pkg::stack_cmd_t cmd,
	output srsc_pkg::rect_t          top,
	output srsc_pkg::rect_t          below,
	output logic [CW-1:0]            count
);

	srsc_pkg::rect_t mem [STACK_DEPTH];
	srsc_pkg::rect_t top_q;
	srsc_pkg::rect_t below_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   refill_idx;

	// entry two below the top, becomes the under-top entry after a pop
	assign refill_idx = count_q - CW'(3);
	assign below = below_q;
	assign top = top_q;
	assign count = count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (apply && cmd.push) begin
			mem[count_q[AW-1:0]] <= cmd.entry;
		end
	end

	// top and under-top copies, each meaningful only while that many entries exist
	always_ff @(posedge clk) begin
		if (apply && cmd.push) begin
			top_q <= cmd.entry;
			below_q <= top_q;
		end else if (apply && cmd.pop) begin
			top_q <= below_q;
			below_q <= mem[refill_idx[AW-1:0]];
		end
	end

	// depth counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply) begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ src/srsc_alu.sv @@
// per-word operation logic: push clamp, pop, overlap test, clip, clear
`default_nettype none
module srsc_alu #(
	parameter int STACK_DEPTH = srsc_pkg::StackDepthDef,
	localparam int CW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic [2:0]                      op,
	input  wire logic signed [srsc_pkg::InW-1:0] rect_x,
	input  wire logic signed [srsc_pkg::InW-1:0] rect_y,
	input  wire logic signed [srsc_pkg::InW-1:0] rect_w,
	input  wire logic signed [srsc_pkg::InW-1:0] rect_h,
	input  wire logic [srsc_pkg::ScreenW-1:0]    screen_width,
	input  wire logic [srsc_pkg::ScreenW-1:0]    screen_height,
	input  wire srsc_pkg::rect_t                 top,
	input  wire srsc_pkg::rect_t                 below,
	input  wire logic [CW-1:0]                   count,
	output srsc_pkg::result_t                    res,
	output srsc_pkg::stack_cmd_t                 cmd,
	output logic [CW-1:0]                        next_count
);

	srsc_pkg::rect_t  screen;
	srsc_pkg::rect_t  cur;
	srsc_pkg::rect_t  pushed;
	srsc_pkg::rect_t  clipped;
	srsc_pkg::span_t  in_sx, in_sy;
	srsc_pkg::span_t  scr_sx, scr_sy;
	srsc_pkg::span_t  cur_sx, cur_sy;
	srsc_pkg::span_t  top_sx, top_sy;
	srsc_pkg::span_t  p1x, p1y, p2x, p2y;
	srsc_pkg::span_t  cx, cy;
	logic             full;
	logic             empty;
	logic             overlap;
	logic             remains;

	// current scissor, full screen when the stack is empty
	assign screen = '{x: '0, y: '0,
		w: srsc_pkg::RectW'(screen_width), h: srsc_pkg::RectW'(screen_height)};
	assign empty = (count == '0);
	assign full = (count == CW'(STACK_DEPTH));
	assign cur = empty ? screen : top;

	// spans in the wide signed domain
	always_comb begin
		in_sx.pos = srsc_pkg::coord_t'(rect_x);
		in_sx.len = srsc_pkg::coord_t'(rect_w);
		in_sy.pos = srsc_pkg::coord_t'(rect_y);
		in_sy.len = srsc_pkg::coord_t'(rect_h);
		scr_sx.pos = '0;
		scr_sx.len = srsc_pkg::coord_t'({1'b0, screen_width});
		scr_sy.pos = '0;
		scr_sy.len = srsc_pkg::coord_t'({1'b0, screen_height});
		cur_sx.pos = srsc_pkg::from_rect(cur.x);
		cur_sx.len = srsc_pkg::from_rect(cur.w);
		cur_sy.pos = srsc_pkg::from_rect(cur.y);
		cur_sy.len = srsc_pkg::from_rect(cur.h);
		top_sx.pos = srsc_pkg::from_rect(top.x);
		top_sx.len = srsc_pkg::from_rect(top.w);
		top_sy.pos = srsc_pkg::from_rect(top.y);
		top_sy.len = srsc_pkg::from_rect(top.h);
	end

	// push: screen first, then the parent entry, sizes floored at zero
	always_comb begin
		p1x = srsc_pkg::clamp_span(in_sx, scr_sx);
		p1y = srsc_pkg::clamp_span(in_sy, scr_sy);
		p2x = empty ? p1x : srsc_pkg::clamp_span(p1x, top_sx);
		p2y = empty ? p1y : srsc_pkg::clamp_span(p1y, top_sy);
		pushed.x = p2x.pos[srsc_pkg::RectW-1:0];
		pushed.y = p2y.pos[srsc_pkg::RectW-1:0];
		pushed.w = (p2x.len > 0) ? p2x.len[srsc_pkg::RectW-1:0] : '0;
		pushed.h = (p2y.len > 0) ? p2y.len[srsc_pkg::RectW-1:0] : '0;
	end

	// clip against the current scissor
	always_comb begin
		cx = srsc_pkg::clamp_span(in_sx, cur_sx);
		cy = srsc_pkg::clamp_span(in_sy, cur_sy);
		remains = (cx.len > 0) && (cy.len > 0);
		clipped.x = cx.pos[srsc_pkg::RectW-1:0];
		clipped.y = cy.pos[srsc_pkg::RectW-1:0];
		clipped.w = remains ? cx.len[srsc_pkg::RectW-1:0] : '0;
		clipped.h = remains ? cy.len[srsc_pkg::RectW-1:0] : '0;
	end

	// overlap test against the current scissor
	assign overlap = (in_sx.pos < cur_sx.pos + cur_sx.len)
		&& (in_sx.pos + in_sx.len > cur_sx.pos)
		&& (in_sy.pos < cur_sy.pos + cur_sy.len)
		&& (in_sy.pos + in_sy.len > cur_sy.pos);

	// operation decode
	always_comb begin
		res.r = cur;
		res.hit = 1'b0;
		res.ignored = 1'b0;
		cmd.push = 1'b0;
		cmd.pop = 1'b0;
		cmd.clear = 1'b0;
		cmd.entry = pushed;
		next_count = count;
		case (srsc_pkg::op_t'(op))
			srsc_pkg::OP_PUSH: begin
				if (full) begin
					res.ignored = 1'b1;
				end else begin
					cmd.push = 1'b1;
					res.r = pushed;
					next_count = count + CW'(1);
				end
			end
			srsc_pkg::OP_POP: begin
				if (empty) begin
					res.ignored = 1'b1;
				end else begin
					cmd.pop = 1'b1;
					next_count = count - CW'(1);
					res.r = (count == CW'(1)) ? screen : below;
				end
			end
			srsc_pkg::OP_TEST: begin
				res.hit = overlap;
			end
			srsc_pkg::OP_CLIP: begin
				res.r = clipped;
				res.hit = remains;
			end
			srsc_pkg::OP_CLEAR: begin
				cmd.clear = 1'b1;
				next_count = '0;
				res.r = screen;
			end
			default: begin
				res.r = cur;
			end
		endcase
	end

endmodule
`default_nettype wire
